// ===== src/edge_orientation_from_curvature_top_defines.svh =====
// Assertion macros shared by the edge orientation block
`ifndef EDGE_ORIENTATION_FROM_CURVATURE_TOP_DEFINES_SVH
`define EDGE_ORIENTATION_FROM_CURVATURE_TOP_DEFINES_SVH

// Flag a condition that must never be true at a clock edge outside reset.
`define EOFC_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// Flag an antecedent that is not met by its consequent in the same cycle.
`define EOFC_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/eofc_pkg.sv =====
// Shared types, constants and the arctangent table of the edge orientation block
`default_nettype none

package eofc_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int CFG_W         = 11;
   localparam int OUT_POS_W     = 10;
   localparam int ORIENT_W      = 16;
   localparam int MIN_DIM       = 3;
   localparam int SLOT_W        = 2;
   localparam int DERIV_W       = 22;
   localparam int ROT_W         = 24;
   localparam int ANGLE_W       = 22;
   localparam int CORDIC_STEPS  = 20;
   localparam int STEP_W        = 5;
   localparam int ATAN_W        = 19;
   localparam int ROUND_SHIFT   = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;
   localparam int SAMPLE_COUNT  = 12;
   localparam int READ_W        = 4;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [ORIENT_W-1:0] ORIENT_VERTICAL = 16'd32768;
   localparam logic [ORIENT_W-1:0] ORIENT_ZERO     = 16'd0;
   localparam logic [ANGLE_W-1:0]  ANGLE_TURN      = 22'd1048576;
   localparam logic [ANGLE_W-1:0]  ROUND_HALF      = 22'd8;

   typedef enum logic [1:0] {
      JOB_STORE,
      JOB_PIXEL,
      JOB_DRAIN
   } job_kind_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // atan(2^-i) in units of pi/2^20
   function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_W-1:0] i);
      logic [ATAN_W-1:0] a;
      case (i)
         5'd0:    a = 19'd262144;
         5'd1:    a = 19'd154753;
         5'd2:    a = 19'd81767;
         5'd3:    a = 19'd41506;
         5'd4:    a = 19'd20834;
         5'd5:    a = 19'd10427;
         5'd6:    a = 19'd5215;
         5'd7:    a = 19'd2608;
         5'd8:    a = 19'd1304;
         5'd9:    a = 19'd652;
         5'd10:   a = 19'd326;
         5'd11:   a = 19'd163;
         5'd12:   a = 19'd81;
         5'd13:   a = 19'd41;
         5'd14:   a = 19'd20;
         5'd15:   a = 19'd10;
         5'd16:   a = 19'd5;
         5'd17:   a = 19'd3;
         5'd18:   a = 19'd1;
         5'd19:   a = 19'd1;
         default: a = 19'd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== src/edge_orientation_from_curvature_top.sv =====
// Top level of the edge orientation block: ports, configuration registers, front, queue, back
//
// Edge orientation from second derivatives. Send unsigned Q0.16 edge
// magnitudes in raster order with req_tuser low; the result word for pixel
// (x,y) leaves once pixel (x,y+2) has come in. After the last pixel of a
// frame, send one drain word (req_tuser high) per pixel of the last two rows
// to flush them; rsp_tlast marks the final result of the frame. Pixel words
// sent while a frame still drains, and drain words sent otherwise, are taken
// and dropped. frame_width and frame_height are clamped to [3, MAX_WIDTH] and
// [3, MAX_HEIGHT] and latched at the first pixel of each frame. Timing: the
// front end takes one word per cycle while its four-entry job queue has room.
// The back end runs one job at a time: a pixel in rows 0 and 1 is only
// written to the line store; every result waits on 12 serial reads of
// its one read port plus 20 steps of the one shared CORDIC rotator.
// The output register holds a finished word while the next job runs.
`default_nettype none

`include "edge_orientation_from_curvature_top_defines.svh"

module edge_orientation_from_curvature_top import eofc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] edge_value
   input  logic        req_tuser,   // [0] opcode
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] orientation, [25:16] col, [35:26] row, zero pad
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int JOB_W = 21 + 3 * ROW_W + 2 * COL_W;

   logic [CFG_W-1:0]     cfg_width_ff;
   logic [CFG_W-1:0]     cfg_height_ff;
   logic                 q_push;
   logic                 q_pop;
   logic [JOB_W-1:0]     q_push_data;
   logic [JOB_W-1:0]     q_pop_data;
   queue_status_type     q_status;
   logic [ORIENT_W-1:0]  orientation;
   logic [OUT_POS_W-1:0] out_col;
   logic [OUT_POS_W-1:0] out_row;

   // registers are always ready; a write takes effect in the next cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: cfg_height_ff <= csr_data;
            default:          cfg_width_ff  <= cfg_width_ff;
         endcase
      end
   end

   // classify words and queue jobs
   eofc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W),
      .JOB_W      (JOB_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .opcode     (req_tuser),
      .edge_value (req_tdata),
      .cfg_width  (cfg_width_ff),
      .cfg_height (cfg_height_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   // decouple the front, which takes one word per cycle while the queue has room, from the multi-cycle back
   eofc_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // line store, derivatives, angle and result register
   eofc_back #(
      .COL_W (COL_W),
      .ROW_W (ROW_W),
      .JOB_W (JOB_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_data          (q_pop_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_orientation (orientation),
      .rsp_col         (out_col),
      .rsp_row         (out_row),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, out_row, out_col, orientation};

   `EOFC_NEVER(queue_overflow_a, q_push && q_status.full, "job queue written while full")
   `EOFC_IMPLY(queue_underflow_a, q_pop, !q_status.empty, "job queue read while empty")

endmodule

`default_nettype wire

// ===== src/eofc_queue.sv =====
// Short job queue between the classifying front end and the compute back end
`default_nettype none

module eofc_queue import eofc_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   assign status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/eofc_front.sv =====
// Front end: accept words, track raster and drain positions, queue jobs
`default_nettype none

module eofc_front import eofc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COL_W      = 10,
   parameter int ROW_W      = 10,
   parameter int JOB_W      = 73
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 opcode,
   input  logic [SAMPLE_W-1:0]  edge_value,
   input  logic [CFG_W-1:0]     cfg_width,
   input  logic [CFG_W-1:0]     cfg_height,
   input  queue_status_type     q_status,
   output logic                 q_push,
   output logic [JOB_W-1:0]     q_data
);

   localparam int FW_W = COL_W + 1;
   localparam int FH_W = ROW_W + 1;

   typedef struct packed {
      job_kind_type        kind;
      logic                frame_end;
      logic [SAMPLE_W-1:0] value;
      logic [ROW_W-1:0]    cur_row;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [FW_W-1:0]     fw;
      logic [FH_W-1:0]     fh;
   } job_type;

   function automatic logic [FW_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
      logic [FW_W-1:0] r;
      if (32'(v) < 32'(MIN_DIM)) r = FW_W'(MIN_DIM);
      else if (32'(v) > 32'(MAX_WIDTH)) r = FW_W'(MAX_WIDTH);
      else r = FW_W'(v);
      return r;
   endfunction

   function automatic logic [FH_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
      logic [FH_W-1:0] r;
      if (32'(v) < 32'(MIN_DIM)) r = FH_W'(MIN_DIM);
      else if (32'(v) > 32'(MAX_HEIGHT)) r = FH_W'(MAX_HEIGHT);
      else r = FH_W'(v);
      return r;
   endfunction

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             draining_ff, draining_in;
   logic [FW_W-1:0]  fw_ff, fw_in;
   logic [FH_W-1:0]  fh_ff, fh_in;

   logic            accept;
   logic            first;
   logic            take_pixel;
   logic            take_drain;
   logic            drain_last;
   logic [FW_W-1:0] fw_use;
   logic [FH_W-1:0] fh_use;
   logic [FW_W-1:0] col_inc;
   logic [FH_W-1:0] row_inc;
   logic [FW_W-1:0] out_col_inc;
   job_type         job;

   assign req_ready = !q_status.full;
   assign q_data    = job;

   always_comb begin
      accept      = req_valid && req_ready;
      first       = (in_col_ff == '0) && (in_row_ff == '0);
      fw_use      = first ? clamp_w(cfg_width) : fw_ff;
      fh_use      = first ? clamp_h(cfg_height) : fh_ff;
      take_pixel  = accept && (opcode == OP_PIXEL) && !draining_ff;
      take_drain  = accept && (opcode == OP_DRAIN) && draining_ff;
      col_inc     = {1'b0, in_col_ff} + 1'b1;
      row_inc     = {1'b0, in_row_ff} + 1'b1;
      out_col_inc = {1'b0, out_col_ff} + 1'b1;
      drain_last  = ({1'b0, out_col_ff} >= fw_ff - 1'b1) &&
                    ({1'b0, out_row_ff} >= fh_ff - 1'b1);

      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      draining_in = draining_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;

      job.kind      = JOB_STORE;
      job.frame_end = 1'b0;
      job.value     = edge_value;
      job.cur_row   = in_row_ff;
      job.row       = in_row_ff;
      job.col       = in_col_ff;
      job.fw        = fw_use;
      job.fh        = fh_use;
      q_push        = 1'b0;

      if (take_pixel) begin
         q_push = 1'b1;
         // rows 0 and 1 only fill the line store
         if (in_row_ff >= ROW_W'(2)) begin
            job.kind = JOB_PIXEL;
            job.row  = in_row_ff - ROW_W'(2);
         end
         fw_in = fw_use;
         fh_in = fh_use;
         if (col_inc >= fw_use) begin
            in_col_in = '0;
            if (row_inc >= fh_use) begin
               in_row_in   = '0;
               draining_in = 1'b1;
               out_col_in  = '0;
               out_row_in  = ROW_W'(fh_use - FH_W'(2));
            end else begin
               in_row_in = row_inc[ROW_W-1:0];
            end
         end else begin
            in_col_in = col_inc[COL_W-1:0];
         end
      end else if (take_drain) begin
         q_push        = 1'b1;
         job.kind      = JOB_DRAIN;
         job.frame_end = drain_last;
         job.cur_row   = out_row_ff;
         job.row       = out_row_ff;
         job.col       = out_col_ff;
         job.fw        = fw_ff;
         job.fh        = fh_ff;
         if (out_col_inc >= fw_ff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_inc[COL_W-1:0];
         end
         if (drain_last) begin
            draining_in = 1'b0;
            out_col_in  = '0;
            out_row_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         draining_ff <= 1'b0;
         fw_ff       <= clamp_w(WIDTH_RESET);
         fh_ff       <= clamp_h(HEIGHT_RESET);
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         draining_ff <= draining_in;
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/eofc_back.sv =====
// Back end: line store, derivative sequencer, CORDIC angle unit and result register
`default_nettype none

module eofc_back import eofc_pkg::*; #(
   parameter int COL_W = 10,
   parameter int ROW_W = 10,
   parameter int JOB_W = 73
) (
   input  logic                 clock,
   input  logic                 reset,
   input  queue_status_type     q_status,
   input  logic [JOB_W-1:0]     q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ORIENT_W-1:0]  rsp_orientation,
   output logic [OUT_POS_W-1:0] rsp_col,
   output logic [OUT_POS_W-1:0] rsp_row,
   output logic                 rsp_last
);

   localparam int FW_W      = COL_W + 1;
   localparam int FH_W      = ROW_W + 1;
   localparam int ADDR_W    = SLOT_W + COL_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam logic signed [DERIV_W-1:0] DERIV_ONE = DERIV_W'(1);

   typedef struct packed {
      job_kind_type        kind;
      logic                frame_end;
      logic [SAMPLE_W-1:0] value;
      logic [ROW_W-1:0]    cur_row;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [FW_W-1:0]     fw;
      logic [FH_W-1:0]     fh;
   } job_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_STORE,
      S_PREP,
      S_READ,
      S_LAST,
      S_DIFF,
      S_SECOND,
      S_SETUP,
      S_ROTATE,
      S_EMIT
   } state_type;

   function automatic logic [COL_W-1:0] col_lo(input logic [COL_W-1:0] c);
      return (c == '0) ? c : c - 1'b1;
   endfunction

   function automatic logic [COL_W-1:0] col_hi(input logic [COL_W-1:0] c,
                                                input logic [FW_W-1:0] n);
      return ({1'b0, c} >= n - 1'b1) ? c : c + 1'b1;
   endfunction

   function automatic logic col_edge(input logic [COL_W-1:0] c, input logic [FW_W-1:0] n);
      return (c == '0) || ({1'b0, c} >= n - 1'b1);
   endfunction

   function automatic logic [ROW_W-1:0] row_lo(input logic [ROW_W-1:0] r);
      return (r == '0) ? r : r - 1'b1;
   endfunction

   function automatic logic [ROW_W-1:0] row_hi(input logic [ROW_W-1:0] r,
                                                input logic [FH_W-1:0] n);
      return ({1'b0, r} >= n - 1'b1) ? r : r + 1'b1;
   endfunction

   function automatic logic row_edge(input logic [ROW_W-1:0] r, input logic [FH_W-1:0] n);
      return (r == '0) || ({1'b0, r} >= n - 1'b1);
   endfunction

   // one-sided difference weighs 4, central difference 2 (both signed Q3.18)
   function automatic logic signed [DERIV_W-1:0] first_diff(input logic [SAMPLE_W-1:0] hi_s,
                                                            input logic [SAMPLE_W-1:0] lo_s,
                                                            input logic one_sided);
      logic signed [DERIV_W-1:0] d;
      d = $signed(DERIV_W'(hi_s)) - $signed(DERIV_W'(lo_s));
      return one_sided ? (d <<< 2) : (d <<< 1);
   endfunction

   // central second differences halve an even sum, so the shift is exact
   function automatic logic signed [DERIV_W-1:0] second_diff(
      input logic signed [DERIV_W-1:0] hi_d,
      input logic signed [DERIV_W-1:0] lo_d,
      input logic one_sided);
      logic signed [DERIV_W-1:0] d;
      d = hi_d - lo_d;
      return one_sided ? d : (d >>> 1);
   endfunction

   state_type                 state_ff;
   job_type                   job_ff;
   job_type                   job_in;
   logic [COL_W-1:0]          clo_ff, chi_ff;
   logic [ROW_W-1:0]          rlo_ff, rhi_ff;
   logic [READ_W-1:0]         rd_k_ff;
   logic                      rd_valid_ff;
   logic                      rd_ovr_ff;
   logic [SAMPLE_W-1:0]       mem_q_ff;
   logic [SAMPLE_W-1:0]       samp_ff [SAMPLE_COUNT];
   logic signed [DERIV_W-1:0] d1_ff [6];
   logic signed [DERIV_W-1:0] dxx_ff, dxy_ff, dyy_ff;
   logic signed [ROT_W-1:0]   x_ff, y_ff;
   logic signed [ANGLE_W-1:0] z_ff;
   logic [STEP_W-1:0]         step_ff;
   logic                      spec_ff;
   logic [ORIENT_W-1:0]       spec_code_ff;
   logic                      rsp_valid_ff;
   logic [ORIENT_W-1:0]       rsp_orient_ff;
   logic [OUT_POS_W-1:0]      rsp_col_ff, rsp_row_ff;
   logic                      rsp_last_ff;

   logic [SAMPLE_W-1:0]       store_mem [MEM_DEPTH];

   logic [ROW_W-1:0]          rd_row;
   logic [COL_W-1:0]          rd_col;
   logic                      rd_ovr;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      mem_we;
   logic [ADDR_W-1:0]         wr_addr;
   logic [SAMPLE_W-1:0]       samp_in;
   logic signed [DERIV_W-1:0] num, den;
   logic signed [ROT_W-1:0]   xs, ys;
   logic signed [ANGLE_W-1:0] at;
   logic signed [ANGLE_W-1:0] zpos;
   logic [ANGLE_W-1:0]        rounded;
   logic                      out_free;

   assign job_in          = q_data;
   assign q_pop           = (state_ff == S_IDLE) && !q_status.empty;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_orientation = rsp_orient_ff;
   assign rsp_col         = rsp_col_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_last        = rsp_last_ff;

   // sample read order: row y around both neighbor columns, rows y-1 and y+1
   // at the neighbor columns, then column x around rows y-1 and y+1
   always_comb begin
      case (rd_k_ff)
         4'd0:    begin rd_row = job_ff.row; rd_col = col_lo(clo_ff);            end
         4'd1:    begin rd_row = job_ff.row; rd_col = col_hi(clo_ff, job_ff.fw); end
         4'd2:    begin rd_row = job_ff.row; rd_col = col_lo(chi_ff);            end
         4'd3:    begin rd_row = job_ff.row; rd_col = col_hi(chi_ff, job_ff.fw); end
         4'd4:    begin rd_row = rlo_ff;     rd_col = clo_ff;                    end
         4'd5:    begin rd_row = rlo_ff;     rd_col = chi_ff;                    end
         4'd6:    begin rd_row = rhi_ff;     rd_col = clo_ff;                    end
         4'd7:    begin rd_row = rhi_ff;     rd_col = chi_ff;                    end
         4'd8:    begin rd_row = row_lo(rlo_ff);            rd_col = job_ff.col; end
         4'd9:    begin rd_row = row_hi(rlo_ff, job_ff.fh); rd_col = job_ff.col; end
         4'd10:   begin rd_row = row_lo(rhi_ff);            rd_col = job_ff.col; end
         4'd11:   begin rd_row = row_hi(rhi_ff, job_ff.fh); rd_col = job_ff.col; end
         default: begin rd_row = job_ff.row; rd_col = job_ff.col;                end
      endcase
      // the arriving pixel has not reached the store yet
      rd_ovr  = (job_ff.kind == JOB_PIXEL) && (rd_row == job_ff.cur_row) &&
                (rd_col == job_ff.col);
      rd_addr = {rd_row[SLOT_W-1:0], rd_col};
      wr_addr = {job_ff.cur_row[SLOT_W-1:0], job_ff.col};
      mem_we  = (state_ff == S_STORE) ||
                ((state_ff == S_DIFF) && (job_ff.kind == JOB_PIXEL));
      samp_in = rd_ovr_ff ? job_ff.value : mem_q_ff;

      num = (dxy_ff > 0) ? -dyy_ff : ((dxy_ff == 0) ? '0 : dyy_ff);
      den = dxx_ff + DERIV_ONE;
      if (den < 0) begin
         num = -num;
         den = -den;
      end

      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = $signed(ANGLE_W'(atan_step(step_ff)));

      zpos     = (z_ff < 0) ? (z_ff + $signed(ANGLE_TURN)) : z_ff;
      rounded  = zpos + ROUND_HALF;
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_addr] <= job_ff.value;
      end
      mem_q_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == S_READ);
         rd_ovr_ff   <= rd_ovr;
         // a word taken while the next one is ready is replaced in S_EMIT
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_valid_ff) begin
            for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
               samp_ff[i] <= samp_ff[i+1];
            end
            samp_ff[SAMPLE_COUNT-1] <= samp_in;
         end

         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  job_ff   <= job_in;
                  state_ff <= (job_in.kind == JOB_STORE) ? S_STORE : S_PREP;
               end
            end
            S_STORE: begin
               state_ff <= S_IDLE;
            end
            S_PREP: begin
               clo_ff   <= col_lo(job_ff.col);
               chi_ff   <= col_hi(job_ff.col, job_ff.fw);
               rlo_ff   <= row_lo(job_ff.row);
               rhi_ff   <= row_hi(job_ff.row, job_ff.fh);
               rd_k_ff  <= '0;
               state_ff <= S_READ;
            end
            S_READ: begin
               rd_k_ff <= rd_k_ff + 1'b1;
               if (rd_k_ff == READ_W'(SAMPLE_COUNT - 1)) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               d1_ff[0] <= first_diff(samp_ff[1], samp_ff[0], col_edge(clo_ff, job_ff.fw));
               d1_ff[1] <= first_diff(samp_ff[3], samp_ff[2], col_edge(chi_ff, job_ff.fw));
               d1_ff[2] <= first_diff(samp_ff[5], samp_ff[4], col_edge(job_ff.col, job_ff.fw));
               d1_ff[3] <= first_diff(samp_ff[7], samp_ff[6], col_edge(job_ff.col, job_ff.fw));
               d1_ff[4] <= first_diff(samp_ff[9], samp_ff[8], row_edge(rlo_ff, job_ff.fh));
               d1_ff[5] <= first_diff(samp_ff[11], samp_ff[10], row_edge(rhi_ff, job_ff.fh));
               state_ff <= S_SECOND;
            end
            S_SECOND: begin
               dxx_ff   <= second_diff(d1_ff[1], d1_ff[0], col_edge(job_ff.col, job_ff.fw));
               dxy_ff   <= second_diff(d1_ff[3], d1_ff[2], row_edge(job_ff.row, job_ff.fh));
               dyy_ff   <= second_diff(d1_ff[5], d1_ff[4], row_edge(job_ff.row, job_ff.fh));
               state_ff <= S_SETUP;
            end
            S_SETUP: begin
               x_ff         <= ROT_W'(den);
               y_ff         <= ROT_W'(num);
               z_ff         <= '0;
               step_ff      <= '0;
               spec_ff      <= (num == 0) || (den == 0);
               spec_code_ff <= (num == 0) ? ORIENT_ZERO : ORIENT_VERTICAL;
               state_ff     <= S_ROTATE;
            end
            S_ROTATE: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + at;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - at;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_orient_ff <= spec_ff ? spec_code_ff : rounded[ROUND_SHIFT +: ORIENT_W];
                  rsp_col_ff    <= OUT_POS_W'(job_ff.col);
                  rsp_row_ff    <= OUT_POS_W'(job_ff.row);
                  rsp_last_ff   <= job_ff.frame_end;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
